// File: hw/rtl/ita_pkg.sv
package ita_pkg;

   localparam int VALUE_W = 32;
   localparam int RADIX_W = 6;
   localparam int LEN_W = 6;
   localparam int RUN_W = 7;
   localparam int REM_W = 7;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W = 8;
   localparam int PFX_W = 2;
   localparam int DIV_BITS = 8;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int DECIMAL_DIGITS = 10;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;

   localparam int SEG_W = 3;
   localparam int NUM_SEGS = 8;

   // Output field sections in the order they are sent.
   typedef enum logic [SEG_W-1:0] {
      SEG_LEAD,
      SEG_SIGN,
      SEG_PFX0,
      SEG_PFXX,
      SEG_ZPAD,
      SEG_PZERO,
      SEG_DIGIT,
      SEG_TRAIL
   } seg_type;

   typedef struct packed {
      logic                  lower_case;
      logic                  alt_prefix;
      logic                  space_sign;
      logic                  force_plus;
      logic                  zero_pad;
      logic                  left_justify;
      logic                  signed_conv;
      logic [LEN_W-1:0]      min_digits;
      logic [LEN_W-1:0]      field_width;
      logic [RADIX_W-1:0]    radix;
      logic [VALUE_W-1:0]    value;
   } req_fields_type;

   localparam int REQ_BITS = $bits(req_fields_type);
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = CHAR_W;

   typedef struct packed {
      logic    load;
      logic    div_step;
      logic    prep;
      logic    seg_load;
      seg_type load_seg;
      seg_type seg;
      logic    emit;
      logic    emit_last;
      logic    emit_bad;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                bad_radix;
      logic                div_done;
      logic [NUM_SEGS-1:0] seg_nonempty;
      logic                run_one;
      logic                out_free;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit,
                                                    input logic lower);
      logic [CHAR_W-1:0] base;
      base = lower ? CHAR_LOWER_A : CHAR_UPPER_A;
      if (digit < DIGIT_W'(DECIMAL_DIGITS)) begin
         return CHAR_ZERO + CHAR_W'(digit);
      end
      return base + CHAR_W'(digit) - CHAR_W'(DECIMAL_DIGITS);
   endfunction

endpackage

// File: hw/rtl/ita_ram.sv
module ita_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ita_ctrl.sv
module ita_ctrl
   import ita_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_DIV,
      S_PREP,
      S_SEL,
      S_EMIT,
      S_BAD
   } state_type;

   state_type state_ff, state_in;
   seg_type   seg_ff, seg_in;
   logic      found;
   seg_type   found_seg;

   // First non-empty section after the current one, or the first one overall.
   always_comb begin
      found = 1'b0;
      found_seg = SEG_DIGIT;
      for (int i = NUM_SEGS - 1; i >= 0; i--) begin
         if (status.seg_nonempty[i] && (state_ff == S_SEL || i > int'(seg_ff))) begin
            found = 1'b1;
            found_seg = seg_type'(SEG_W'(i));
         end
      end
   end

   always_comb begin
      cmd = '0;
      cmd.seg = seg_ff;
      cmd.load_seg = found_seg;
      state_in = state_ff;
      seg_in = seg_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = status.bad_radix ? S_BAD : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.seg_load = 1'b1;
            seg_in = found_seg;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.run_one) begin
                  if (found) begin
                     cmd.seg_load = 1'b1;
                     seg_in = found_seg;
                  end else begin
                     cmd.emit_last = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_BAD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.emit_bad = 1'b1;
               cmd.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seg_ff <= SEG_LEAD;
      end else begin
         state_ff <= state_in;
         seg_ff <= seg_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("Item sent while the output register was occupied.");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> status.seg_nonempty[seg_ff])
      else $error("Sending from an empty section.");

   a_sel_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEL) |-> found)
      else $error("No non-empty section found after conversion.");

endmodule

// File: hw/rtl/ita_dp.sv
module ita_dp
   import ita_pkg::*;
#(
   parameter int MAX_DIGITS = 32,
   parameter int MAX_FIELD = 60
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   req_fields_type req;

   logic [VALUE_W-1:0] work_ff, work_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [LEN_W-1:0]   fw_ff, fw_in;
   logic [LEN_W-1:0]   prec_ff, prec_in;
   logic               has_sign_ff, has_sign_in;
   logic [CHAR_W-1:0]  sign_char_ff, sign_char_in;
   logic [PFX_W-1:0]   pfx_len_ff, pfx_len_in;
   logic               left_ff, left_in;
   logic               zpad_ff, zpad_in;
   logic               lower_ff, lower_in;
   logic               bad_ff, bad_in;
   logic [RUN_W-1:0]   pz_ff, pz_in;
   logic [RUN_W-1:0]   pad_ff, pad_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic               negative;
   logic [REM_W-1:0]   div_rem;
   logic [VALUE_W-1:0] div_work;
   logic               step_last;
   logic [RUN_W-1:0]   prec_eff;
   logic [RUN_W-1:0]   used;
   logic [RUN_W-1:0]   fw_run;
   logic [RUN_W-1:0]   seg_len [NUM_SEGS];
   logic [CHAR_W-1:0]  emit_char;
   logic               wr_en;
   logic               rd_en;
   logic               rd_top;
   logic [CNT_W-1:0]   top_idx;
   logic [RUN_W-1:0]   next_idx;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DIGIT_W-1:0] rd_digit;

   assign req = req_fields_type'(req_tdata[REQ_BITS-1:0]);
   assign negative = req.signed_conv & req.value[VALUE_W-1];

   // Eight restoring-division steps per cycle; the quotient shifts into the work register.
   always_comb begin
      div_rem = (step_ff == '0) ? '0 : rem_ff;
      div_work = work_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         div_rem = {div_rem[REM_W-2:0], div_work[VALUE_W-1]};
         div_work = {div_work[VALUE_W-2:0], 1'b0};
         if (div_rem >= REM_W'(radix_ff)) begin
            div_rem = div_rem - REM_W'(radix_ff);
            div_work[0] = 1'b1;
         end
      end
   end

   assign step_last = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign wr_en = cmd.div_step && step_last && (cnt_ff < CNT_W'(MAX_DIGITS));

   always_comb begin
      prec_eff = (RUN_W'(prec_ff) > RUN_W'(cnt_ff)) ? RUN_W'(prec_ff) : RUN_W'(cnt_ff);
      used = RUN_W'(has_sign_ff) + RUN_W'(pfx_len_ff) + prec_eff;
      fw_run = RUN_W'(fw_ff);
   end

   always_comb begin
      seg_len[SEG_LEAD] = (!left_ff && !zpad_ff) ? pad_ff : '0;
      seg_len[SEG_SIGN] = RUN_W'(has_sign_ff);
      seg_len[SEG_PFX0] = RUN_W'(pfx_len_ff != '0);
      seg_len[SEG_PFXX] = RUN_W'(pfx_len_ff == PFX_W'(2));
      seg_len[SEG_ZPAD] = (!left_ff && zpad_ff) ? pad_ff : '0;
      seg_len[SEG_PZERO] = pz_ff;
      seg_len[SEG_DIGIT] = RUN_W'(cnt_ff);
      seg_len[SEG_TRAIL] = left_ff ? pad_ff : '0;
   end

   always_comb begin
      status.bad_radix = bad_ff;
      status.div_done = step_last && (div_work == '0);
      for (int i = 0; i < NUM_SEGS; i++) begin
         status.seg_nonempty[i] = (seg_len[i] != '0);
      end
      status.run_one = (run_ff == RUN_W'(1));
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   // Digits are stored least significant first and read back from the top.
   assign rd_top = cmd.seg_load && (cmd.load_seg == SEG_DIGIT);
   assign rd_en = rd_top || (cmd.emit && !cmd.emit_bad && cmd.seg == SEG_DIGIT);
   assign top_idx = cnt_ff - CNT_W'(1);
   assign next_idx = run_ff - RUN_W'(2);
   assign rd_addr = rd_top ? top_idx[ADDR_W-1:0] : next_idx[ADDR_W-1:0];

   ita_ram #(
      .WIDTH(DIGIT_W),
      .DEPTH(MAX_DIGITS)
   ) u_digits (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(cnt_ff[ADDR_W-1:0]),
      .wr_data(div_rem[DIGIT_W-1:0]),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_digit)
   );

   always_comb begin
      case (cmd.seg) inside
         SEG_LEAD, SEG_TRAIL: emit_char = CHAR_SPACE;
         SEG_SIGN: emit_char = sign_char_ff;
         SEG_PFX0, SEG_ZPAD, SEG_PZERO: emit_char = CHAR_ZERO;
         SEG_PFXX: emit_char = lower_ff ? CHAR_LOWER_X : CHAR_UPPER_X;
         SEG_DIGIT: emit_char = digit_char(rd_digit, lower_ff);
         default: emit_char = CHAR_NUL;
      endcase
   end

   always_comb begin
      work_in = work_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      radix_in = radix_ff;
      fw_in = fw_ff;
      prec_in = prec_ff;
      has_sign_in = has_sign_ff;
      sign_char_in = sign_char_ff;
      pfx_len_in = pfx_len_ff;
      left_in = left_ff;
      zpad_in = zpad_ff;
      lower_in = lower_ff;
      bad_in = bad_ff;
      pz_in = pz_ff;
      pad_in = pad_ff;
      run_in = run_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in = rsp_bad_ff;

      if (cmd.load) begin
         work_in = negative ? (VALUE_W'(0) - req.value) : req.value;
         step_in = '0;
         cnt_in = '0;
         radix_in = req.radix;
         fw_in = (req.field_width > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : req.field_width;
         prec_in = (req.min_digits > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : req.min_digits;
         has_sign_in = negative || req.force_plus || req.space_sign;
         if (negative) begin
            sign_char_in = CHAR_MINUS;
         end else if (req.force_plus) begin
            sign_char_in = CHAR_PLUS;
         end else begin
            sign_char_in = CHAR_SPACE;
         end
         if (!req.alt_prefix) begin
            pfx_len_in = PFX_W'(0);
         end else if (req.radix == RADIX_HEX) begin
            pfx_len_in = PFX_W'(2);
         end else if (req.radix == RADIX_OCT) begin
            pfx_len_in = PFX_W'(1);
         end else begin
            pfx_len_in = PFX_W'(0);
         end
         left_in = req.left_justify;
         zpad_in = req.zero_pad;
         lower_in = req.lower_case;
         bad_in = (req.radix < RADIX_MIN) || (req.radix > RADIX_MAX);
      end

      if (cmd.div_step) begin
         work_in = div_work;
         rem_in = div_rem;
         step_in = step_ff + STEP_W'(1);
         if (wr_en) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.prep) begin
         pz_in = prec_eff - RUN_W'(cnt_ff);
         pad_in = (fw_run > used) ? (fw_run - used) : '0;
      end

      if (cmd.seg_load) begin
         run_in = seg_len[cmd.load_seg];
      end else if (cmd.emit && !cmd.emit_bad) begin
         run_in = run_ff - RUN_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = cmd.emit_bad ? CHAR_NUL : emit_char;
         rsp_last_in = cmd.emit_last;
         rsp_bad_in = cmd.emit_bad;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         cnt_ff <= '0;
         bad_ff <= 1'b0;
         run_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         cnt_ff <= cnt_in;
         bad_ff <= bad_in;
         run_ff <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff <= work_in;
      rem_ff <= rem_in;
      radix_ff <= radix_in;
      fw_ff <= fw_in;
      prec_ff <= prec_in;
      has_sign_ff <= has_sign_in;
      sign_char_ff <= sign_char_in;
      pfx_len_ff <= pfx_len_in;
      left_ff <= left_in;
      zpad_ff <= zpad_in;
      lower_ff <= lower_in;
      pz_ff <= pz_in;
      pad_ff <= pad_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_char_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_bad_ff;

   a_run_live: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.emit_bad) |-> (run_ff != '0))
      else $error("Character sent from an exhausted section.");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIGITS))
      else $error("Digit count exceeds the digit store depth.");

   a_bad_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && rsp_char_ff == CHAR_NUL))
      else $error("Radix error item is not a single null character.");

endmodule

// File: hw/rtl/integer_to_ascii_formatter_core.sv
// Formats one integer per request as printf-style ASCII characters.
// The request channel (req_*) carries the value, radix, field width, precision
// and flags. The result channel (rsp_*) sends one character per item, with
// rsp_tlast on the final character of the field.
// An invalid radix (outside 2 to 36) gives a single item with a null character
// and rsp_tuser set.
// A request first runs a digit loop that produces D digits, where D is up to
// 32 in radix 2 and up to 10 in radix 10, and then sends its characters. In
// the digit loop one divide-by-radix unit retires eight quotient bits per
// cycle. Characters then leave at one per cycle while the receiver is ready.
// An invalid radix skips the digit loop and sends its single item directly.
// A new request is taken once the final character of the previous one sits
// in the output register. When the receiver stalls, the output register holds
// its character and the block waits. Reset returns the block to idle and
// drops any character not yet taken.
module integer_to_ascii_formatter_core
   import ita_pkg::*;
#(
   parameter int MAX_DIGITS = 32,
   parameter int MAX_FIELD = 60
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // value, radix, field_width, min_digits, signed_conv, left_justify,
   // zero_pad, force_plus, space_sign, alt_prefix, lower_case
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_char
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // bad_radix
   output logic                   rsp_tuser
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ita_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ita_dp #(
      .MAX_DIGITS(MAX_DIGITS),
      .MAX_FIELD (MAX_FIELD)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ita_pkg::*;

   localparam int N_ITEMS = 460;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_CHARS = 200;
   localparam int MAX_REPORTS = 50;
   localparam int FIELD_LIMIT = 60;

   localparam logic [6:0] FLAG_SIGNED = 7'h01;
   localparam logic [6:0] FLAG_LEFT = 7'h02;
   localparam logic [6:0] FLAG_ZPAD = 7'h04;
   localparam logic [6:0] FLAG_PLUS = 7'h08;
   localparam logic [6:0] FLAG_SPACE = 7'h10;
   localparam logic [6:0] FLAG_ALT = 7'h20;
   localparam logic [6:0] FLAG_LOWER = 7'h40;

   localparam int STALL_NONE = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_PERIODIC = 2;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              bad;
   } char_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   logic [REQ_TDATA_W-1:0] pending_reqs[$];
   char_item_type          expected_chars[$];

   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   int error_count = 0;
   int reqs_taken = 0;
   int chars_checked = 0;
   int bad_radix_seen = 0;
   int longest_field = 0;
   int field_len = 0;
   int idle_cycles = 0;

   integer_to_ascii_formatter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [REQ_TDATA_W-1:0] make_req(input logic [VALUE_W-1:0] value,
                                                       input logic [RADIX_W-1:0] radix,
                                                       input logic [LEN_W-1:0] width,
                                                       input logic [LEN_W-1:0] digits,
                                                       input logic [6:0] flags);
      req_fields_type r;
      r.value = value;
      r.radix = radix;
      r.field_width = width;
      r.min_digits = digits;
      {r.lower_case, r.alt_prefix, r.space_sign, r.force_plus, r.zero_pad,
       r.left_justify, r.signed_conv} = flags;
      return REQ_TDATA_W'(r);
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] random_req();
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic [LEN_W-1:0]   width;
      logic [LEN_W-1:0]   digits;
      int                 pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: value = $urandom_range(0, 20);
         1: begin
            case ($urandom_range(0, 5))
               0: value = 32'h0000_0000;
               1: value = 32'h0000_0001;
               2: value = 32'h7FFF_FFFF;
               3: value = 32'h8000_0000;
               4: value = 32'h8000_0001;
               default: value = 32'hFFFF_FFFF;
            endcase
         end
         2: value = 32'd0 - $urandom_range(1, 1000);
         default: value = $urandom;
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         radix = RADIX_W'($urandom_range(0, 1));
      end else if (pick == 1) begin
         radix = RADIX_W'($urandom_range(37, 63));
      end else if (pick < 12) begin
         case ($urandom_range(0, 4))
            0: radix = 6'd2;
            1: radix = RADIX_OCT;
            2: radix = 6'd10;
            3: radix = RADIX_HEX;
            default: radix = RADIX_MAX;
         endcase
      end else begin
         radix = RADIX_W'($urandom_range(2, 36));
      end
      width = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(40, 63))
                                           : LEN_W'($urandom_range(0, 24));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         digits = LEN_W'($urandom_range(30, 63));
      end else if (pick < 6) begin
         digits = '0;
      end else begin
         digits = LEN_W'($urandom_range(1, 16));
      end
      return make_req(value, radix, width, digits, 7'($urandom_range(0, 127)));
   endfunction

   // Builds the full formatted field for one request and queues its characters.
   function automatic void predict_field(input req_fields_type r);
      char_item_type     chars[$];
      int unsigned       digit_vals[$];
      int unsigned       mag, base, width, prec, prefix_len, used, pad, d;
      logic [CHAR_W-1:0] sign_char;
      logic [CHAR_W-1:0] letter_a;
      if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
         expected_chars.push_back('{ch: CHAR_NUL, last: 1'b1, bad: 1'b1});
         return;
      end
      base = 32'(r.radix);
      width = (r.field_width > LEN_W'(FIELD_LIMIT)) ? FIELD_LIMIT : 32'(r.field_width);
      prec = (r.min_digits > LEN_W'(FIELD_LIMIT)) ? FIELD_LIMIT : 32'(r.min_digits);
      letter_a = r.lower_case ? CHAR_LOWER_A : CHAR_UPPER_A;
      sign_char = CHAR_NUL;
      if (r.signed_conv && r.value[VALUE_W-1]) begin
         sign_char = CHAR_MINUS;
         mag = ~r.value + 32'd1;
      end else begin
         mag = r.value;
         if (r.force_plus) begin
            sign_char = CHAR_PLUS;
         end else if (r.space_sign) begin
            sign_char = CHAR_SPACE;
         end
      end
      prefix_len = 0;
      if (r.alt_prefix && r.radix == RADIX_HEX) begin
         prefix_len = 2;
      end else if (r.alt_prefix && r.radix == RADIX_OCT) begin
         prefix_len = 1;
      end
      if (mag == 0) begin
         digit_vals.push_front(0);
      end
      while (mag != 0) begin
         digit_vals.push_front(mag % base);
         mag = mag / base;
      end
      if (digit_vals.size() > prec) begin
         prec = digit_vals.size();
      end
      used = (sign_char != CHAR_NUL ? 1 : 0) + prefix_len + prec;
      pad = (width > used) ? width - used : 0;
      if (!r.left_justify && !r.zero_pad) begin
         repeat (pad) chars.push_back('{ch: CHAR_SPACE, last: 1'b0, bad: 1'b0});
      end
      if (sign_char != CHAR_NUL) begin
         chars.push_back('{ch: sign_char, last: 1'b0, bad: 1'b0});
      end
      if (prefix_len >= 1) begin
         chars.push_back('{ch: CHAR_ZERO, last: 1'b0, bad: 1'b0});
      end
      if (prefix_len == 2) begin
         chars.push_back('{ch: r.lower_case ? CHAR_LOWER_X : CHAR_UPPER_X,
                           last: 1'b0, bad: 1'b0});
      end
      if (!r.left_justify && r.zero_pad) begin
         repeat (pad) chars.push_back('{ch: CHAR_ZERO, last: 1'b0, bad: 1'b0});
      end
      repeat (prec - digit_vals.size()) begin
         chars.push_back('{ch: CHAR_ZERO, last: 1'b0, bad: 1'b0});
      end
      foreach (digit_vals[i]) begin
         d = digit_vals[i];
         chars.push_back('{ch: (d < 10) ? CHAR_ZERO + CHAR_W'(d)
                                         : letter_a + CHAR_W'(d - 10),
                           last: 1'b0, bad: 1'b0});
      end
      if (r.left_justify) begin
         repeat (pad) chars.push_back('{ch: CHAR_SPACE, last: 1'b0, bad: 1'b0});
      end
      chars[chars.size() - 1].last = 1'b1;
      foreach (chars[i]) expected_chars.push_back(chars[i]);
   endfunction

   // Request sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tdata <= pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: stall pattern changes every so often, one long hold-off.
   int stall_mode = STALL_NONE;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_phase = 0;

   always @(negedge clock) begin
      stall_phase++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && chars_checked >= HOLD_AFTER_CHARS) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_RANDOM: rsp_tready <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: rsp_tready <= (stall_phase % 5 != 0);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Monitor and scoreboard; also the watchdog on accepted items.
   always @(posedge clock) begin
      char_item_type want;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fire) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: unexpected item: data %h last %b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            field_len++;
            if (rsp_tdata !== want.ch) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: character mismatch: expected %h actual %h",
                           $time, want.ch, rsp_tdata);
               end
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: tlast mismatch: expected %b actual %b",
                           $time, want.last, rsp_tlast);
               end
            end
            if (rsp_tuser !== want.bad) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: tuser mismatch: expected %b actual %b",
                           $time, want.bad, rsp_tuser);
               end
            end
            if (want.bad) begin
               bad_radix_seen++;
            end
            if (want.last) begin
               if (field_len > longest_field) begin
                  longest_field = field_len;
               end
               field_len = 0;
            end
         end
      end
      if (req_fire) begin
         predict_field(req_fields_type'(req_tdata[REQ_BITS-1:0]));
         reqs_taken++;
      end
      if (reset || req_fire || rsp_fire) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d characters still expected",
                     $time, IDLE_LIMIT, expected_chars.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      pending_reqs.push_back(make_req(32'd0, 6'd10, 6'd0, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'hFFFF_FFFF, 6'd10, 6'd0, 6'd0, FLAG_SIGNED));
      pending_reqs.push_back(make_req(32'h8000_0000, 6'd10, 6'd12, 6'd0,
                                      FLAG_SIGNED | FLAG_PLUS));
      pending_reqs.push_back(make_req(32'h7FFF_FFFF, 6'd10, 6'd0, 6'd0,
                                      FLAG_SIGNED | FLAG_PLUS));
      pending_reqs.push_back(make_req(32'h0000_1234, 6'd10, 6'd8, 6'd0, FLAG_SPACE));
      pending_reqs.push_back(make_req(32'h0000_1234, 6'd10, 6'd8, 6'd0,
                                      FLAG_PLUS | FLAG_SPACE));
      pending_reqs.push_back(make_req(32'hFFFF_FFFF, 6'd2, 6'd63, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'hFFFF_FFFF, RADIX_MAX, 6'd0, 6'd0, FLAG_LOWER));
      pending_reqs.push_back(make_req(32'hDEAD_BEEF, RADIX_MAX, 6'd0, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'h0000_BEEF, RADIX_HEX, 6'd20, 6'd0,
                                      FLAG_ALT | FLAG_ZPAD));
      pending_reqs.push_back(make_req(32'h0000_BEEF, RADIX_HEX, 6'd20, 6'd0,
                                      FLAG_ALT | FLAG_LOWER | FLAG_LEFT | FLAG_ZPAD));
      pending_reqs.push_back(make_req(32'd0, RADIX_OCT, 6'd0, 6'd0, FLAG_ALT));
      pending_reqs.push_back(make_req(32'o777, RADIX_OCT, 6'd6, 6'd10,
                                      FLAG_ALT | FLAG_SIGNED));
      pending_reqs.push_back(make_req(32'd5, 6'd2, 6'd0, 6'd0, FLAG_ALT));
      pending_reqs.push_back(make_req(32'd0, RADIX_HEX, 6'd0, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'd0, 6'd10, 6'd5, 6'd63, FLAG_PLUS));
      pending_reqs.push_back(make_req(32'h8000_0000, RADIX_HEX, 6'd63, 6'd63,
                                      FLAG_SIGNED | FLAG_ALT));
      pending_reqs.push_back(make_req(32'd42, 6'd10, 6'd63, 6'd0, FLAG_LEFT | FLAG_PLUS));
      pending_reqs.push_back(make_req(32'd42, 6'd10, 6'd61, 6'd3, FLAG_ZPAD | FLAG_SIGNED));
      pending_reqs.push_back(make_req(32'd99, 6'd0, 6'd10, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'd99, 6'd1, 6'd10, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'd99, 6'd37, 6'd10, 6'd0, 7'h00));
      pending_reqs.push_back(make_req(32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 7'h7F));
      pending_reqs.push_back(make_req(32'hFFFF_FFFF, 6'd10, 6'd63, 6'd62, 7'h7F));
      pending_reqs.push_back(make_req(32'd1, 6'd3, 6'd0, 6'd0, 7'h00));
      while (pending_reqs.size() < N_ITEMS) begin
         pending_reqs.push_back(random_req());
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (reqs_taken < N_ITEMS);
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Formatted %0d requests into %0d characters, %0d of them bad-radix items;",
               reqs_taken, chars_checked, bad_radix_seen);
      $display("longest field %0d characters, receiver held off once for %0d cycles.",
               longest_field, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: integer_to_ascii_formatter_core.f
hw/rtl/ita_pkg.sv
hw/rtl/ita_ram.sv
hw/rtl/ita_ctrl.sv
hw/rtl/ita_dp.sv
hw/rtl/integer_to_ascii_formatter_core.sv
tb/tb.sv
